[rtl/ini_key_entry_scanner_unit_macros.svh]
// Assertion macros used by the key scanner top level.
`ifndef INI_KEY_ENTRY_SCANNER_UNIT_MACROS_SVH
`define INI_KEY_ENTRY_SCANNER_UNIT_MACROS_SVH

// Same-cycle property, checked out of reset.
`define IKES_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Antecedent this cycle, consequent on the next clock.
`define IKES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ikes_pkg.sv]
// Shared types and constants for the key=value entry scanner.
package ikes_pkg;

    localparam int NAME_MAX    = 31;
    localparam int OFFSET_BITS = 32;
    localparam int NAME_BITS   = $clog2(NAME_MAX + 1);
    localparam int IDX_BITS    = $clog2(NAME_MAX);
    localparam int KEY_CHARS   = 31;
    localparam int KLEN_BITS   = 5;
    localparam int OUT_OFS     = 32;
    localparam int CFG_DATA    = 64;
    localparam int CFG_ADDR    = 6;
    localparam int CHARS_3_W   = 56;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    typedef enum logic [2:0] {
        REG_KEY_LENGTH  = 3'd0,
        REG_KEY_CHARS_0 = 3'd1,
        REG_KEY_CHARS_1 = 3'd2,
        REG_KEY_CHARS_2 = 3'd3,
        REG_KEY_CHARS_3 = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic [KLEN_BITS-1:0]      key_length;
        logic [KEY_CHARS-1:0][7:0] chars;
    } t_key_cfg;

    typedef struct packed {
        logic               found;
        logic [OUT_OFS-1:0] value_offset;
        logic [OUT_OFS-1:0] line_offset;
    } t_scan_res;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_LC_A && c <= CH_LC_Z) begin
            r = c - CASE_GAP;
        end
        return r;
    endfunction

endpackage

[rtl/ikes_cfg_regs.sv]
// APB register file holding the key length and key characters.
module ikes_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ikes_pkg::CFG_ADDR-1:0] paddr,
    input  logic [ikes_pkg::CFG_DATA-1:0] pwdata,
    output logic [ikes_pkg::CFG_DATA-1:0] prdata,
    output logic                          pready,
    output ikes_pkg::t_key_cfg            o_key
);
    import ikes_pkg::*;

    logic [KLEN_BITS-1:0] r_key_length;
    logic [CFG_DATA-1:0]  r_chars_0;
    logic [CFG_DATA-1:0]  r_chars_1;
    logic [CFG_DATA-1:0]  r_chars_2;
    logic [CHARS_3_W-1:0] r_chars_3;
    logic                 wr_en;
    t_cfg_reg             reg_sel;
    logic [KEY_CHARS*8-1:0] flat_chars;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = t_cfg_reg'(paddr[CFG_ADDR-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= KLEN_BITS'(1);
            r_chars_0    <= '0;
            r_chars_1    <= '0;
            r_chars_2    <= '0;
            r_chars_3    <= '0;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_KEY_LENGTH:  r_key_length <= pwdata[KLEN_BITS-1:0];
                REG_KEY_CHARS_0: r_chars_0    <= pwdata;
                REG_KEY_CHARS_1: r_chars_1    <= pwdata;
                REG_KEY_CHARS_2: r_chars_2    <= pwdata;
                REG_KEY_CHARS_3: r_chars_3    <= pwdata[CHARS_3_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            REG_KEY_LENGTH:  prdata = CFG_DATA'(r_key_length);
            REG_KEY_CHARS_0: prdata = r_chars_0;
            REG_KEY_CHARS_1: prdata = r_chars_1;
            REG_KEY_CHARS_2: prdata = r_chars_2;
            REG_KEY_CHARS_3: prdata = CFG_DATA'(r_chars_3);
            default:         prdata = '0;
        endcase
    end

    // char k sits at bits 8k upward across the four words
    assign flat_chars = {r_chars_3, r_chars_2, r_chars_1, r_chars_0};

    always_comb begin
        o_key.key_length = r_key_length;
        for (int k = 0; k < KEY_CHARS; k++) begin
            o_key.chars[k] = flat_chars[8*k +: 8];
        end
    end

endmodule

[rtl/ikes_scan_core.sv]
// Line scanner: name buffer, comment/match state, offsets and key compare.
module ikes_scan_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  logic [7:0]          i_byte,
    input  logic                i_restart,
    input  ikes_pkg::t_key_cfg  i_key,
    output ikes_pkg::t_scan_res o_res
);
    import ikes_pkg::*;

    logic [7:0]             r_name [NAME_MAX];
    logic [NAME_BITS-1:0]   r_name_count;
    logic                   r_in_comment;
    logic                   r_match_done;
    logic [OFFSET_BITS-1:0] r_byte_pos;
    logic [OFFSET_BITS-1:0] r_line_start;
    logic [OFFSET_BITS-1:0] r_value_start;

    logic [NAME_BITS-1:0]   n_name_count;
    logic                   n_in_comment;
    logic                   n_match_done;
    logic [OFFSET_BITS-1:0] n_byte_pos;
    logic [OFFSET_BITS-1:0] n_line_start;
    logic [OFFSET_BITS-1:0] n_value_start;

    // state as seen by this byte, after an optional restart
    logic [NAME_BITS-1:0]   cur_count;
    logic                   cur_comment;
    logic                   cur_match;
    logic [OFFSET_BITS-1:0] cur_pos;
    logic [OFFSET_BITS-1:0] cur_line;
    logic [OFFSET_BITS-1:0] cur_value;

    logic [OFFSET_BITS-1:0] next_pos;
    logic                   is_end;
    logic                   key_hit;
    logic                   name_wr;

    assign cur_count   = i_restart ? '0 : r_name_count;
    assign cur_comment = i_restart ? 1'b0 : r_in_comment;
    assign cur_match   = i_restart ? 1'b0 : r_match_done;
    assign cur_pos     = i_restart ? '0 : r_byte_pos;
    assign cur_line    = i_restart ? '0 : r_line_start;
    assign cur_value   = i_restart ? '0 : r_value_start;

    assign next_pos = cur_pos + OFFSET_BITS'(1);
    assign is_end   = (i_byte == CH_NUL) || (i_byte == CH_CR) || (i_byte == CH_LF);

    // prefix compare; entries at or above the key length are masked off
    always_comb begin
        key_hit = ({1'b0, cur_count} >= (NAME_BITS+1)'(i_key.key_length));
        for (int k = 0; k < NAME_MAX; k++) begin
            if (KLEN_BITS'(k) < i_key.key_length && r_name[k] != i_key.chars[k]) begin
                key_hit = 1'b0;
            end
        end
    end

    always_comb begin
        n_name_count  = cur_count;
        n_in_comment  = cur_comment;
        n_match_done  = cur_match;
        n_byte_pos    = cur_pos;
        n_line_start  = cur_line;
        n_value_start = cur_value;
        name_wr       = 1'b0;
        if (!cur_match) begin
            if (cur_comment) begin
                if (is_end) begin
                    n_in_comment = 1'b0;
                    n_line_start = next_pos;
                end
            end else if (is_end) begin
                n_name_count = '0;
                n_line_start = next_pos;
            end else if (i_byte == CH_EQ) begin
                if (cur_count != '0 && key_hit) begin
                    n_match_done  = 1'b1;
                    n_value_start = next_pos;
                end
            end else if (i_byte == CH_HASH) begin
                if (cur_count == '0) begin
                    n_in_comment = 1'b1;
                end
            end else if (i_byte != CH_SPACE) begin
                if (cur_count < NAME_BITS'(NAME_MAX)) begin
                    name_wr      = 1'b1;
                    n_name_count = cur_count + NAME_BITS'(1);
                end
            end
            if (!n_match_done) begin
                n_byte_pos = next_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_count  <= '0;
            r_in_comment  <= 1'b0;
            r_match_done  <= 1'b0;
            r_byte_pos    <= '0;
            r_line_start  <= '0;
            r_value_start <= '0;
        end else if (i_adv) begin
            r_name_count  <= n_name_count;
            r_in_comment  <= n_in_comment;
            r_match_done  <= n_match_done;
            r_byte_pos    <= n_byte_pos;
            r_line_start  <= n_line_start;
            r_value_start <= n_value_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && name_wr) begin
            r_name[cur_count[IDX_BITS-1:0]] <= to_upper(i_byte);
        end
    end

    assign o_res.found        = n_match_done;
    assign o_res.value_offset = n_match_done ? OUT_OFS'(n_value_start) : '0;
    assign o_res.line_offset  = n_match_done ? OUT_OFS'(n_line_start) : '0;

endmodule

[rtl/ini_key_entry_scanner_unit.sv]
// Top level of the key=value entry scanner: stream handshake and result register.
//
// Takes one text byte per clock and returns one result per byte via the input, then the
// result register. A new byte can be taken every cycle while results are taken. While a
// result waits at the output, one more byte is held in the input register and the input
// then stalls. The name buffer, key compare and offsets update as each byte advances.
// Set the key over the APB port (key_length at 0x00, key characters at 0x08..0x20,
// 64-bit data) only while the stream is idle; the block does not enforce this. restart
// in tuser clears the search and the offset before its byte.
module ini_key_entry_scanner_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ikes_pkg::CFG_ADDR-1:0] paddr,
    input  logic [ikes_pkg::CFG_DATA-1:0] pwdata,
    output logic [ikes_pkg::CFG_DATA-1:0] prdata,
    output logic                          pready,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,  // [7:0] text_byte
    input  logic                          i_s_tuser,  // [0] restart
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [63:0]                   o_m_tdata,  // [31:0] value_offset, [63:32] line_offset
    output logic                          o_m_tuser   // [0] found
);
    import ikes_pkg::*;
    `include "ini_key_entry_scanner_unit_macros.svh"

    t_key_cfg  key_cfg;
    t_scan_res scan_res;
    t_scan_res r_out;
    logic      r_out_valid;
    logic      r_in_valid;
    logic [7:0] r_in_byte;
    logic      r_in_restart;
    logic      advance;

    ikes_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_key   (key_cfg)
    );

    ikes_scan_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (advance),
        .i_byte    (r_in_byte),
        .i_restart (r_in_restart),
        .i_key     (key_cfg),
        .o_res     (scan_res)
    );

    // byte moves on when the result register is empty or being emptied
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte    <= i_s_tdata;
            r_in_restart <= i_s_tuser;
        end
        if (advance) begin
            r_out <= scan_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.found;
    assign o_m_tdata  = {r_out.line_offset, r_out.value_offset};

    `IKES_ASSERT_NEXT(a_held_byte_kept, r_in_valid && !advance, r_in_valid, "held byte dropped")
    `IKES_ASSERT(a_ready_when_empty, !r_out_valid |-> o_s_tready, "stalled with empty output")
    `IKES_ASSERT(a_offsets_zero, o_m_tvalid && !o_m_tuser |-> o_m_tdata == '0, "offsets without match")

endmodule
